FILE: rtl/core/momc_pkg.sv
// shared types, codes and lookup functions for the output mode controller
package momc_pkg;

    localparam int NUM_CH   = 10;
    localparam int NUM_UNIT = 7;

    // command codes
    localparam logic [2:0] FUNC_SET_MODE  = 3'd0;
    localparam logic [2:0] FUNC_SET_VALUE = 3'd1;
    localparam logic [2:0] FUNC_GET_VALUE = 3'd2;
    localparam logic [2:0] FUNC_GET_MODE  = 3'd3;
    localparam logic [2:0] FUNC_TICK      = 3'd4;

    // channel modes
    localparam logic [2:0] MODE_DISCRETE = 3'd0;
    localparam logic [2:0] MODE_PWM      = 3'd1;
    localparam logic [2:0] MODE_SERVO    = 3'd2;
    localparam logic [2:0] MODE_UART     = 3'd3;
    localparam logic [2:0] MODE_SPI      = 3'd4;
    localparam logic [2:0] MODE_I2C      = 3'd5;

    // result status codes
    localparam logic [1:0] ST_DONE         = 2'd0;
    localparam logic [1:0] ST_BAD_CHANNEL  = 2'd1;
    localparam logic [1:0] ST_MODE_UNAVAIL = 2'd2;

    localparam logic [15:0] SERVO_IDLE     = 16'h0200;
    localparam logic [15:0] READ_INVALID   = 16'hFFFF;
    localparam logic [9:0]  FULL_DUTY      = 10'h3FF;
    localparam logic [9:0]  DUTY_LSB_CLEAR = 10'h3FC;
    localparam logic [7:0]  PIN_ALL        = 8'hFF;

    // per-channel memory word
    typedef struct packed {
        logic [15:0] setpoint;
        logic [2:0]  mode;
    } chan_word_t;

    // per-unit memory word
    typedef struct packed {
        logic       enabled;
        logic [9:0] duty;
    } unit_word_t;

    // compare unit that serves a channel
    function automatic logic [2:0] unit_of(input logic [3:0] ch);
        logic [3:0] u;
        u = (ch < 4'd4) ? 4'd0 : ch - 4'd3;
        return u[2:0];
    endfunction

    // fixed set of modes each channel supports
    function automatic logic mode_allowed(input logic [3:0] ch, input logic [2:0] nm);
        logic ok;
        case (ch) inside
            [4'd0:4'd3]: ok = nm inside {MODE_DISCRETE, MODE_SERVO};
            4'd4, 4'd5:  ok = nm inside {MODE_DISCRETE, MODE_PWM, MODE_SERVO, MODE_I2C};
            4'd6, 4'd7:  ok = nm inside {MODE_DISCRETE, MODE_PWM, MODE_SERVO};
            4'd8, 4'd9:  ok = nm inside {MODE_PWM, MODE_SERVO};
            default:     ok = 1'b0;
        endcase
        return ok;
    endfunction

    // contents of a channel entry after reset
    function automatic chan_word_t chan_reset(input logic [3:0] ch);
        chan_word_t w;
        w.setpoint = SERVO_IDLE;
        w.mode     = (ch < 4'd8) ? MODE_DISCRETE : MODE_PWM;
        return w;
    endfunction

endpackage

FILE: rtl/core/momc_ram.sv
// generic single-clock ram with one write port and one registered read port
module momc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write, then registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/multichannel_output_mode_controller_unit.sv
// ten-channel output mode controller: command sequencer over channel and unit memories
//
// Each request is a command (set mode, set value, get value, get mode, servo tick) and
// gives one result, or for a servo tick up to two compare unit updates, the final one
// flagged by last. Channel mode and servo setpoint live in a 10-entry memory, unit duty
// and enable in a 7-entry memory, both with a registered read; per-entry
// valid flops stand in for the reset contents, so no clearing pass is needed after reset.
// A request reads its channel entry (S_CHAN_A), then gives its result (S_EMIT) when it
// touches no compare unit, or reads and writes back one unit (S_UREQ, S_UWR). An odd
// servo tick also reads the next channel (S_CHAN_B) and, when it releases one unit and
// drives another, does a read and a write-back per unit, all bound by the single read
// port of each memory. A finished result sits in an output register, so the next
// request is taken while it waits for the consumer.
module multichannel_output_mode_controller_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [3:0]  channel,
    input  logic [2:0]  new_mode,
    input  logic [15:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] read_data,
    output logic [1:0]  status,
    output logic        unit_write_valid,
    output logic [2:0]  unit_index,
    output logic [9:0]  unit_duty,
    output logic        unit_enabled,
    output logic [7:0]  pin_levels,
    output logic [7:0]  pin_tristate,
    output logic [3:0]  steering_bits,
    output logic        last
);
    import momc_pkg::*;

    localparam int CW = $bits(chan_word_t);
    localparam int UW = $bits(unit_word_t);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHAN_A = 3'd1;
    localparam logic [2:0] S_CHAN_B = 3'd2;
    localparam logic [2:0] S_UREQ   = 3'd3;
    localparam logic [2:0] S_UWR    = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    // unit operation kinds
    localparam logic [1:0] OP_SET_DUTY = 2'd0;
    localparam logic [1:0] OP_MODE_CHG = 2'd1;
    localparam logic [1:0] OP_READ     = 2'd2;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  func_reg, func_next;
    logic [3:0]  ch_reg, ch_next;
    logic [2:0]  nm_reg, nm_next;
    logic [15:0] val_reg, val_next;
    logic [3:0]  addr_reg, addr_next;
    logic [3:0]  slot_new_reg, slot_new_next;
    logic        ua_reg, ua_next;
    logic [2:0]  uaddr_reg, uaddr_next;

    logic [2:0]  op_unit_reg [2];
    logic [2:0]  op_unit_next [2];
    logic [1:0]  op_kind_reg [2];
    logic [1:0]  op_kind_next [2];
    logic [9:0]  op_duty_reg [2];
    logic [9:0]  op_duty_next [2];
    logic        op_en_reg [2];
    logic        op_en_next [2];
    logic        op_idx_reg, op_idx_next;
    logic        op_last_reg, op_last_next;

    logic [15:0] emit_rd_reg, emit_rd_next;
    logic [1:0]  emit_st_reg, emit_st_next;

    logic [7:0]  pin_mask_reg, pin_mask_next;
    logic [7:0]  pin_level_reg, pin_level_next;
    logic [7:0]  pin_tri_reg, pin_tri_next;
    logic [3:0]  steer_reg, steer_next;
    logic [3:0]  shift_reg, shift_next;
    logic [3:0]  slot_reg, slot_next;
    logic        phase_reg, phase_next;
    logic [NUM_CH-1:0]   chan_vld_reg, chan_vld_next;
    logic [NUM_UNIT-1:0] unit_vld_reg, unit_vld_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] o_rd_reg, o_rd_next;
    logic [1:0]  o_st_reg, o_st_next;
    logic        o_uwv_reg, o_uwv_next;
    logic [2:0]  o_uidx_reg, o_uidx_next;
    logic [9:0]  o_duty_reg, o_duty_next;
    logic        o_en_reg, o_en_next;
    logic [7:0]  o_pin_reg, o_pin_next;
    logic [7:0]  o_tri_reg, o_tri_next;
    logic [3:0]  o_steer_reg, o_steer_next;
    logic        o_last_reg, o_last_next;

    // memory ports
    logic          c_we, c_re;
    logic [3:0]    c_waddr, c_raddr;
    logic [CW-1:0] c_wdata, c_rdata;
    logic          u_we, u_re;
    logic [2:0]    u_waddr, u_raddr;
    logic [UW-1:0] u_wdata, u_rdata;

    chan_word_t  chan_cur;
    unit_word_t  unit_cur;
    logic        out_free;
    logic        ch_ok;
    logic [7:0]  bit_sel;
    logic [7:0]  lvl_tmp;
    logic [3:0]  shift_eff;

    momc_ram #(.WIDTH(CW), .DEPTH(NUM_CH)) u_chan_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .re    (c_re),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    momc_ram #(.WIDTH(UW), .DEPTH(NUM_UNIT)) u_unit_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .re    (u_re),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    // read data with reset contents for entries never written
    assign chan_cur = chan_vld_reg[addr_reg] ? chan_word_t'(c_rdata) : chan_reset(addr_reg);
    assign unit_cur = unit_vld_reg[uaddr_reg] ? unit_word_t'(u_rdata) : unit_word_t'('0);

    assign out_free = !out_valid_reg || !out_stall;
    assign ch_ok    = ch_reg < 4'(NUM_CH);
    assign bit_sel  = 8'b1 << ch_reg[2:0];
    assign in_stall = (state_reg != S_IDLE);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        ch_next        = ch_reg;
        nm_next        = nm_reg;
        val_next       = val_reg;
        addr_next      = addr_reg;
        slot_new_next  = slot_new_reg;
        ua_next        = ua_reg;
        uaddr_next     = uaddr_reg;
        op_unit_next   = op_unit_reg;
        op_kind_next   = op_kind_reg;
        op_duty_next   = op_duty_reg;
        op_en_next     = op_en_reg;
        op_idx_next    = op_idx_reg;
        op_last_next   = op_last_reg;
        emit_rd_next   = emit_rd_reg;
        emit_st_next   = emit_st_reg;
        pin_mask_next  = pin_mask_reg;
        pin_level_next = pin_level_reg;
        pin_tri_next   = pin_tri_reg;
        steer_next     = steer_reg;
        shift_next     = shift_reg;
        slot_next      = slot_reg;
        phase_next     = phase_reg;
        chan_vld_next  = chan_vld_reg;
        unit_vld_next  = unit_vld_reg;

        out_valid_next = out_valid_reg && out_stall;
        o_rd_next      = o_rd_reg;
        o_st_next      = o_st_reg;
        o_uwv_next     = o_uwv_reg;
        o_uidx_next    = o_uidx_reg;
        o_duty_next    = o_duty_reg;
        o_en_next      = o_en_reg;
        o_pin_next     = o_pin_reg;
        o_tri_next     = o_tri_reg;
        o_steer_next   = o_steer_reg;
        o_last_next    = o_last_reg;

        c_we    = 1'b0;
        c_waddr = ch_reg;
        c_wdata = chan_cur;
        c_re    = 1'b0;
        c_raddr = addr_reg;
        u_we    = 1'b0;
        u_waddr = uaddr_reg;
        u_wdata = unit_cur;
        u_re    = 1'b0;
        u_raddr = op_unit_reg[op_idx_reg];

        lvl_tmp   = (val_reg != 16'd0) ? (pin_level_reg | bit_sel) : (pin_level_reg & ~bit_sel);
        shift_eff = (slot_new_reg == 4'd0) ? 4'h8 : shift_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = func;
                    ch_next   = channel;
                    nm_next   = new_mode;
                    val_next  = value;
                    if (func == FUNC_TICK)
                    begin
                        addr_next = slot_reg;
                    end
                    else
                    begin
                        addr_next = (channel < 4'(NUM_CH)) ? channel : 4'd0;
                    end
                    c_re       = 1'b1;
                    c_raddr    = addr_next;
                    op_idx_next  = 1'b0;
                    op_last_next = 1'b0;
                    emit_rd_next = 16'd0;
                    emit_st_next = ST_DONE;
                    state_next   = S_CHAN_A;
                end
            end

            S_CHAN_A:
            begin
                state_next = S_EMIT;
                if (func_reg == FUNC_TICK)
                begin
                    if (phase_reg)
                    begin
                        // odd phase: note release of old slot, fetch the next slot
                        ua_next         = (chan_cur.mode == MODE_SERVO);
                        op_unit_next[0] = unit_of(addr_reg);
                        op_kind_next[0] = OP_SET_DUTY;
                        op_duty_next[0] = 10'd0;
                        slot_new_next   = (addr_reg == 4'(NUM_CH - 1)) ? 4'd0 : addr_reg + 4'd1;
                        addr_next       = slot_new_next;
                        c_re            = 1'b1;
                        c_raddr         = slot_new_next;
                        state_next      = S_CHAN_B;
                    end
                    else
                    begin
                        // even phase: load the setpoint
                        phase_next = 1'b1;
                        if (chan_cur.mode == MODE_SERVO)
                        begin
                            op_unit_next[0] = unit_of(addr_reg);
                            op_kind_next[0] = OP_SET_DUTY;
                            op_duty_next[0] = chan_cur.setpoint[9:0];
                            state_next      = S_UREQ;
                        end
                    end
                end
                else if (func_reg > FUNC_TICK)
                begin
                    emit_rd_next = 16'd0;
                end
                else if (!ch_ok)
                begin
                    emit_rd_next = READ_INVALID;
                    emit_st_next = ST_BAD_CHANNEL;
                end
                else
                begin
                    case (func_reg)
                        FUNC_SET_MODE:
                        begin
                            if (!mode_allowed(ch_reg, nm_reg))
                            begin
                                emit_st_next = ST_MODE_UNAVAIL;
                            end
                            else
                            begin
                                c_we    = 1'b1;
                                c_wdata = {chan_cur.setpoint, nm_reg};
                                chan_vld_next[ch_reg] = 1'b1;
                                if (ch_reg < 4'd8)
                                begin
                                    pin_mask_next = (nm_reg == MODE_DISCRETE) ?
                                                    (pin_mask_reg | bit_sel) :
                                                    (pin_mask_reg & ~bit_sel);
                                    if (ch_reg >= 4'd4)
                                    begin
                                        pin_tri_next = (nm_reg == MODE_I2C) ?
                                                       (pin_tri_reg | bit_sel) :
                                                       (pin_tri_reg & ~bit_sel);
                                        op_unit_next[0] = unit_of(ch_reg);
                                        op_kind_next[0] = OP_MODE_CHG;
                                        op_en_next[0]   = (nm_reg == MODE_PWM) ||
                                                          (nm_reg == MODE_SERVO);
                                        state_next      = S_UREQ;
                                    end
                                end
                            end
                        end

                        FUNC_SET_VALUE:
                        begin
                            case (chan_cur.mode)
                                MODE_DISCRETE:
                                begin
                                    if (ch_reg < 4'd8)
                                    begin
                                        pin_level_next = lvl_tmp & pin_mask_reg;
                                    end
                                end
                                MODE_PWM:
                                begin
                                    op_unit_next[0] = unit_of(ch_reg);
                                    op_kind_next[0] = OP_SET_DUTY;
                                    op_duty_next[0] = val_reg[9:0];
                                    state_next      = S_UREQ;
                                end
                                MODE_SERVO:
                                begin
                                    c_we    = 1'b1;
                                    c_wdata = {val_reg, chan_cur.mode};
                                    chan_vld_next[ch_reg] = 1'b1;
                                end
                                default:
                                begin
                                end
                            endcase
                        end

                        FUNC_GET_VALUE:
                        begin
                            case (chan_cur.mode)
                                MODE_PWM:
                                begin
                                    op_unit_next[0] = unit_of(ch_reg);
                                    op_kind_next[0] = OP_READ;
                                    state_next      = S_UREQ;
                                end
                                MODE_SERVO:
                                begin
                                    emit_rd_next = chan_cur.setpoint;
                                end
                                default:
                                begin
                                    emit_rd_next = (ch_reg < 4'd8) ?
                                                   {15'd0, pin_level_reg[ch_reg[2:0]]} : 16'd0;
                                end
                            endcase
                        end

                        FUNC_GET_MODE:
                        begin
                            emit_rd_next = {13'd0, chan_cur.mode};
                        end

                        default:
                        begin
                        end
                    endcase
                end
            end

            S_CHAN_B:
            begin
                // odd phase: advance round-robin and steer the shared unit
                slot_next  = slot_new_reg;
                phase_next = 1'b0;
                if (slot_new_reg < 4'd4)
                begin
                    steer_next = (chan_cur.mode == MODE_SERVO) ? shift_eff : 4'd0;
                    shift_next = shift_eff >> 1;
                end
                else
                begin
                    steer_next = 4'd0;
                    shift_next = shift_eff;
                end
                state_next = S_UREQ;
                if (ua_reg && (chan_cur.mode == MODE_SERVO))
                begin
                    op_unit_next[1] = unit_of(slot_new_reg);
                    op_kind_next[1] = OP_SET_DUTY;
                    op_duty_next[1] = FULL_DUTY;
                    op_last_next    = 1'b1;
                end
                else if (chan_cur.mode == MODE_SERVO)
                begin
                    op_unit_next[0] = unit_of(slot_new_reg);
                    op_kind_next[0] = OP_SET_DUTY;
                    op_duty_next[0] = FULL_DUTY;
                end
                else if (!ua_reg)
                begin
                    state_next = S_EMIT;
                end
            end

            S_UREQ:
            begin
                u_re       = 1'b1;
                u_raddr    = op_unit_reg[op_idx_reg];
                uaddr_next = op_unit_reg[op_idx_reg];
                state_next = S_UWR;
            end

            S_UWR:
            begin
                // modify, write back and report the unit, or for a read report its duty
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_rd_next      = 16'd0;
                    o_st_next      = ST_DONE;
                    o_uwv_next     = 1'b1;
                    o_uidx_next    = uaddr_reg;
                    o_pin_next     = pin_level_reg;
                    o_tri_next     = pin_tri_reg;
                    o_steer_next   = steer_reg;
                    o_last_next    = (op_idx_reg == op_last_reg);
                    case (op_kind_reg[op_idx_reg])
                        OP_SET_DUTY:
                        begin
                            u_we        = 1'b1;
                            u_wdata     = {unit_cur.enabled, op_duty_reg[op_idx_reg]};
                            o_duty_next = op_duty_reg[op_idx_reg];
                            o_en_next   = unit_cur.enabled;
                            unit_vld_next[uaddr_reg] = 1'b1;
                        end
                        OP_MODE_CHG:
                        begin
                            u_we        = 1'b1;
                            u_wdata     = {op_en_reg[op_idx_reg], unit_cur.duty & DUTY_LSB_CLEAR};
                            o_duty_next = unit_cur.duty & DUTY_LSB_CLEAR;
                            o_en_next   = op_en_reg[op_idx_reg];
                            unit_vld_next[uaddr_reg] = 1'b1;
                        end
                        default:
                        begin
                            o_rd_next   = {6'd0, unit_cur.duty};
                            o_uwv_next  = 1'b0;
                            o_uidx_next = 3'd0;
                            o_duty_next = 10'd0;
                            o_en_next   = 1'b0;
                        end
                    endcase
                    if (op_idx_reg == op_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        op_idx_next = 1'b1;
                        state_next  = S_UREQ;
                    end
                end
            end

            S_EMIT:
            begin
                // single result with no unit update
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_rd_next      = emit_rd_reg;
                    o_st_next      = emit_st_reg;
                    o_uwv_next     = 1'b0;
                    o_uidx_next    = 3'd0;
                    o_duty_next    = 10'd0;
                    o_en_next      = 1'b0;
                    o_pin_next     = pin_level_reg;
                    o_tri_next     = pin_tri_reg;
                    o_steer_next   = steer_reg;
                    o_last_next    = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pin_mask_reg  <= PIN_ALL;
            pin_level_reg <= 8'd0;
            pin_tri_reg   <= PIN_ALL;
            steer_reg     <= 4'd0;
            shift_reg     <= 4'd1;
            slot_reg      <= 4'd0;
            phase_reg     <= 1'b1;
            chan_vld_reg  <= '0;
            unit_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pin_mask_reg  <= pin_mask_next;
            pin_level_reg <= pin_level_next;
            pin_tri_reg   <= pin_tri_next;
            steer_reg     <= steer_next;
            shift_reg     <= shift_next;
            slot_reg      <= slot_next;
            phase_reg     <= phase_next;
            chan_vld_reg  <= chan_vld_next;
            unit_vld_reg  <= unit_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        ch_reg       <= ch_next;
        nm_reg       <= nm_next;
        val_reg      <= val_next;
        addr_reg     <= addr_next;
        slot_new_reg <= slot_new_next;
        ua_reg       <= ua_next;
        uaddr_reg    <= uaddr_next;
        op_unit_reg  <= op_unit_next;
        op_kind_reg  <= op_kind_next;
        op_duty_reg  <= op_duty_next;
        op_en_reg    <= op_en_next;
        op_idx_reg   <= op_idx_next;
        op_last_reg  <= op_last_next;
        emit_rd_reg  <= emit_rd_next;
        emit_st_reg  <= emit_st_next;
        o_rd_reg     <= o_rd_next;
        o_st_reg     <= o_st_next;
        o_uwv_reg    <= o_uwv_next;
        o_uidx_reg   <= o_uidx_next;
        o_duty_reg   <= o_duty_next;
        o_en_reg     <= o_en_next;
        o_pin_reg    <= o_pin_next;
        o_tri_reg    <= o_tri_next;
        o_steer_reg  <= o_steer_next;
        o_last_reg   <= o_last_next;
    end

    assign out_valid        = out_valid_reg;
    assign read_data        = o_rd_reg;
    assign status           = o_st_reg;
    assign unit_write_valid = o_uwv_reg;
    assign unit_index       = o_uidx_reg;
    assign unit_duty        = o_duty_reg;
    assign unit_enabled     = o_en_reg;
    assign pin_levels       = o_pin_reg;
    assign pin_tristate     = o_tri_reg;
    assign steering_bits    = o_steer_reg;
    assign last             = o_last_reg;

endmodule

FILE: rtl/core/momc_checker.sv
// port-level checks on the output mode controller results, bound to the top level
module momc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] read_data,
    input logic [1:0]  status,
    input logic        unit_write_valid,
    input logic [2:0]  unit_index,
    input logic [9:0]  unit_duty,
    input logic        unit_enabled,
    input logic [3:0]  steering_bits
);
    import momc_pkg::*;

    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(status)
            && $stable(unit_duty) && $stable(unit_index))
        else $error("result changed while stalled");

    // no unit report means zeroed unit fields
    a_unit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !unit_write_valid |-> unit_index == 3'd0 && unit_duty == 10'd0
            && !unit_enabled)
        else $error("unit fields set without a unit update");

    // bad channel answers all ones and touches no unit
    a_bad_ch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_BAD_CHANNEL |-> read_data == READ_INVALID
            && !unit_write_valid)
        else $error("bad channel result malformed");

    // unit reports only on successful commands, for existing units
    a_unit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unit_write_valid |-> status == ST_DONE && unit_index < 3'd7
            && read_data == 16'd0)
        else $error("unit report malformed");

    // shared unit steers at most one channel
    a_steer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0(steering_bits))
        else $error("steering not one-hot");

endmodule

bind multichannel_output_mode_controller_unit momc_checker u_momc_checker (.*);
